/* design/hds_pkg.sv */
// ----------------------------------------------------------------------------
// hds_pkg
// Shared types and constants of the HID descriptor scanner.
// ----------------------------------------------------------------------------
package hds_pkg;

   localparam int unsigned MAX_REPORT = 8;

   localparam logic [15:0] HEADER_BYTES   = 16'd9;
   localparam logic [15:0] POS_MAX        = 16'hFFFF;
   localparam logic [7:0]  TYPE_INTERFACE = 8'h04;
   localparam logic [7:0]  TYPE_ENDPOINT  = 8'h05;
   localparam logic [7:0]  CLASS_HID      = 8'h03;
   localparam logic [7:0]  EMPTY_IF       = 8'hFF;
   localparam logic [7:0]  OFFSET_MAX     = 8'hFF;
   localparam logic [7:0]  OFF_TYPE       = 8'd1;
   localparam logic [7:0]  OFF_NUMBER     = 8'd2;
   localparam logic [7:0]  OFF_CLASS      = 8'd5;
   localparam int unsigned EP_DIR_BIT     = 7;

   typedef struct packed {
      logic [7:0] iface;
      logic [3:0] ep_in;
      logic [3:0] ep_out;
   } slot_entry_type;

   // Result item, lowest field in the lowest bits.
   typedef struct packed {
      logic       bad_descriptor;
      logic [3:0] out_endpoint;
      logic [3:0] in_endpoint;
      logic [7:0] interface_number;
      logic       slot_valid;
      logic [2:0] slot_index;
   } rsp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* design/hds_front.sv */
// ----------------------------------------------------------------------------
// hds_front
// Byte parser: follows the descriptor chain and builds the slot table.
// ----------------------------------------------------------------------------
module hds_front import hds_pkg::*; #(
   parameter int unsigned SLOT_COUNT = 8,
   parameter int unsigned REPORT_N   = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] desc_byte
   input  logic                             req_tlast,  // final_byte
   input  queue_status_type                 q_status,
   output logic                             push,
   output logic                             push_halted,
   output slot_entry_type [REPORT_N-1:0]    push_slots
);

   localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int unsigned UW = $clog2(SLOT_COUNT + 1);

   logic [15:0]    pos_ff, pos_in;
   logic [15:0]    nds_ff, nds_in;
   logic [7:0]     off_ff, off_in;
   logic [7:0]     type_ff, type_in;
   logic [7:0]     pend_ff, pend_in;
   logic [SW-1:0]  cur_ff, cur_in;
   logic           cur_valid_ff, cur_valid_in;
   logic [UW-1:0]  used_ff, used_in;
   logic           halted_ff, halted_in;
   slot_entry_type table_ff [SLOT_COUNT];
   slot_entry_type table_in [SLOT_COUNT];

   logic           accept;
   logic           step_pos;
   logic [16:0]    next_sum;
   logic [7:0]     b;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign next_sum   = {1'b0, pos_ff} + {9'd0, b};

   always_comb begin
      pos_in       = pos_ff;
      nds_in       = nds_ff;
      off_in       = off_ff;
      type_in      = type_ff;
      pend_in      = pend_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      used_in      = used_ff;
      halted_in    = halted_ff;
      table_in     = table_ff;
      step_pos     = 1'b0;
      push         = 1'b0;
      push_halted  = 1'b0;
      push_slots   = '0;

      if (accept && !halted_ff) begin
         step_pos = 1'b1;
         if (pos_ff >= HEADER_BYTES) begin
            if (pos_ff == nds_ff) begin
               // length byte: zero or past the 16-bit range stops the parse
               if (b == 8'd0 || next_sum[16]) begin
                  halted_in = 1'b1;
                  step_pos  = 1'b0;
               end else begin
                  nds_in  = next_sum[15:0];
                  off_in  = 8'd0;
                  type_in = 8'd0;
               end
            end else begin
               off_in = (off_ff != OFFSET_MAX) ? off_ff + 8'd1 : off_ff;
               if (off_in == OFF_TYPE) begin
                  type_in = b;
                  if (b == TYPE_INTERFACE) begin
                     cur_valid_in = 1'b0;
                  end
               end else if (off_in == OFF_NUMBER) begin
                  if (type_ff == TYPE_INTERFACE) begin
                     pend_in = b;
                  end else if (type_ff == TYPE_ENDPOINT && cur_valid_ff) begin
                     if (b[EP_DIR_BIT]) begin
                        table_in[cur_ff].ep_in = b[3:0];
                     end else begin
                        table_in[cur_ff].ep_out = b[3:0];
                     end
                  end
               end else if (off_in == OFF_CLASS && type_ff == TYPE_INTERFACE &&
                            b == CLASS_HID) begin
                  if (used_ff < UW'(SLOT_COUNT)) begin
                     cur_in                  = used_ff[SW-1:0];
                     table_in[used_ff[SW-1:0]].iface = pend_ff;
                     cur_valid_in            = 1'b1;
                     if (pend_ff != EMPTY_IF) begin
                        used_in = used_ff + UW'(1);
                     end
                  end else begin
                     cur_valid_in = 1'b0;
                  end
               end
            end
         end
         if (step_pos && pos_ff != POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end
      end

      if (accept && req_tlast) begin
         // snapshot the table including this byte, then start a new parse
         push        = 1'b1;
         push_halted = halted_in;
         for (int i = 0; i < int'(REPORT_N); i++) begin
            push_slots[i] = table_in[i];
         end
         pos_in       = '0;
         nds_in       = HEADER_BYTES;
         off_in       = '0;
         type_in      = '0;
         pend_in      = '0;
         cur_in       = '0;
         cur_valid_in = 1'b0;
         used_in      = '0;
         halted_in    = 1'b0;
         for (int i = 0; i < int'(SLOT_COUNT); i++) begin
            table_in[i] = '{iface: EMPTY_IF, ep_in: 4'd0, ep_out: 4'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         nds_ff       <= HEADER_BYTES;
         off_ff       <= '0;
         type_ff      <= '0;
         pend_ff      <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         used_ff      <= '0;
         halted_ff    <= 1'b0;
         for (int i = 0; i < int'(SLOT_COUNT); i++) begin
            table_ff[i] <= '{iface: EMPTY_IF, ep_in: 4'd0, ep_out: 4'd0};
         end
      end else begin
         pos_ff       <= pos_in;
         nds_ff       <= nds_in;
         off_ff       <= off_in;
         type_ff      <= type_in;
         pend_ff      <= pend_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         used_ff      <= used_in;
         halted_ff    <= halted_in;
         table_ff     <= table_in;
      end
   end

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (pos_ff == '0 && !halted_ff && used_ff == '0))
      else $error("parser did not restart after final byte");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(SLOT_COUNT))
      else $error("slot fill count exceeds table size");

endmodule

/* design/hds_queue.sv */
// ----------------------------------------------------------------------------
// hds_queue
// Two-entry queue of table snapshots between parser and reporter.
// ----------------------------------------------------------------------------
module hds_queue import hds_pkg::*; #(
   parameter int unsigned REPORT_N = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          push_halted,
   input  slot_entry_type [REPORT_N-1:0] push_slots,
   input  logic                          pop,
   output logic                          head_halted,
   output slot_entry_type [REPORT_N-1:0] head_slots,
   output queue_status_type              q_status
);

   slot_entry_type [REPORT_N-1:0] slots_ff [2];
   logic           halted_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);
   assign head_slots     = slots_ff[rd_ptr_ff];
   assign head_halted    = halted_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff]  <= push_slots;
         halted_ff[wr_ptr_ff] <= push_halted;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("snapshot pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("snapshot popped from an empty queue");

endmodule

/* design/hds_back.sv */
// ----------------------------------------------------------------------------
// hds_back
// Reporter: walks the head snapshot one slot per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module hds_back import hds_pkg::*; #(
   parameter int unsigned REPORT_N = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  queue_status_type              q_status,
   input  logic                          head_halted,
   input  slot_entry_type [REPORT_N-1:0] head_slots,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output rsp_item_type                  rsp_item,
   output logic                          rsp_tlast
);

   localparam int unsigned RW = (REPORT_N > 1) ? $clog2(REPORT_N) : 1;

   logic [RW-1:0]  cnt_ff, cnt_in;
   logic           valid_ff, valid_in;
   rsp_item_type   item_ff, item_in;
   logic           last_ff, last_in;
   logic           load;
   logic           at_last;
   slot_entry_type cur;

   assign load    = !q_status.empty && (!valid_ff || rsp_tready);
   assign at_last = (cnt_ff == RW'(REPORT_N - 1));
   assign pop     = load && at_last;
   assign cur     = head_slots[cnt_ff];

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      item_in  = item_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in                 = 1'b1;
         item_in.slot_index       = 3'(cnt_ff);
         item_in.slot_valid       = (cur.iface != EMPTY_IF);
         item_in.interface_number = cur.iface;
         item_in.in_endpoint      = cur.ep_in;
         item_in.out_endpoint     = cur.ep_out;
         item_in.bad_descriptor   = head_halted;
         last_in                  = at_last;
         cnt_in                   = at_last ? '0 : cnt_ff + RW'(1);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;
   assign rsp_tlast  = last_ff;

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> (item_ff.slot_index == 3'(REPORT_N - 1)))
      else $error("last flag on a slot other than the final one");

endmodule

/* design/hid_descriptor_scanner_unit.sv */
// ----------------------------------------------------------------------------
// hid_descriptor_scanner_unit
// Scans a USB configuration descriptor and reports its HID interface table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one descriptor byte per item in req_tdata[7:0]; req_tlast
//   marks a descriptor's final byte; the parser takes one byte per cycle while req_tready is high.
//   rsp channel: after the final byte, one item per table slot (at most 8),
//   slot 0 first; rsp_tlast is set on the item of the last slot.
//   Timing: the final byte's snapshot is registered into the queue, then the
//   reporter loads the first result item into its output register; the rest
//   follow at one per cycle while rsp_tready is high.
//   Throughput: one byte per cycle while req_tready is high. A two-entry
//   snapshot queue sits between parser and reporter, so the parser keeps
//   taking bytes of the next descriptor while a report drains; req_tready
//   drops only while two reports are waiting, which happens when descriptors
//   shorter than the report length arrive back to back or the receiver stalls.
//   Reset: synchronous, active high; clears the parser, empties the table
//   (interface 0xFF, endpoints 0) and drops any pending reports.
//   Receiver stall: the output register holds its item, the queue fills,
//   then req_tready falls until the reporter loads the last slot of the
//   oldest report into its output register.
// ----------------------------------------------------------------------------
module hid_descriptor_scanner_unit import hds_pkg::*; #(
   parameter int unsigned SLOT_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] desc_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] slot_index, [3] slot_valid, [11:4] interface_number,
   // [15:12] in_endpoint, [19:16] out_endpoint, [20] bad_descriptor, [23:21] zero
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast    // last_slot
);

   // only the first eight slots are reported
   localparam int unsigned REPORT_N = (SLOT_COUNT < MAX_REPORT) ? SLOT_COUNT : MAX_REPORT;

   queue_status_type              q_status;
   logic                          push;
   logic                          push_halted;
   slot_entry_type [REPORT_N-1:0] push_slots;
   logic                          pop;
   logic                          head_halted;
   slot_entry_type [REPORT_N-1:0] head_slots;
   rsp_item_type                  rsp_item;

   // parse bytes, build the table, push a snapshot on the final byte
   hds_front #(
      .SLOT_COUNT (SLOT_COUNT),
      .REPORT_N   (REPORT_N)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .q_status    (q_status),
      .push        (push),
      .push_halted (push_halted),
      .push_slots  (push_slots)
   );

   // hold up to two finished tables
   hds_queue #(
      .REPORT_N (REPORT_N)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_halted (push_halted),
      .push_slots  (push_slots),
      .pop         (pop),
      .head_halted (head_halted),
      .head_slots  (head_slots),
      .q_status    (q_status)
   );

   // emit one slot per cycle from the oldest table while rsp_tready allows
   hds_back #(
      .REPORT_N (REPORT_N)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head_halted (head_halted),
      .head_slots  (head_slots),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_item    (rsp_item),
      .rsp_tlast   (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_item};

endmodule
